// File: src/ffba_pkg.sv
`default_nettype none
package ffba_pkg;

  localparam int unsigned DEF_HEAP_BYTES   = 65536;
  localparam int unsigned DEF_HEADER_BYTES = 12;
  localparam int unsigned DEF_MAX_BLOCKS   = 64;

  localparam logic [31:0] HEAP_BASE_RST = 32'h0020_0000;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned REQ_W    = 17;
  localparam int unsigned STATUS_W = 2;

  // stream payload widths, rounded up to whole bytes
  localparam int unsigned S_TDATA_W = ((REQ_W + ADDR_W + 7) / 8) * 8;
  localparam int unsigned M_TDATA_W = ((ADDR_W + STATUS_W + 7) / 8) * 8;

  localparam logic FN_ALLOC   = 1'b0;
  localparam logic FN_RELEASE = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_NO_FIT   = 2'd1,
    ST_BAD_ADDR = 2'd2
  } status_t;

endpackage
`default_nettype wire

// File: src/ffba_block_mem.sv
`default_nettype none
module ffba_block_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned ENT_W = 41,
  parameter logic [ENT_W-1:0] RST_ENTRY = '0
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [ENT_W-1:0]              rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [ENT_W-1:0]         wr_data
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic [ENT_W-1:0] mem [DEPTH];
  logic [ENT_W-1:0] rd_q;
  logic             e0_valid;
  logic             rd_rst;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  // entry 0 holds the initial free block until it is first written
  always_ff @(posedge clk) begin
    if (rst) begin
      e0_valid <= 1'b0;
      rd_rst   <= 1'b0;
    end else begin
      if (wr_en && wr_addr == AW'(0)) begin
        e0_valid <= 1'b1;
      end
      if (rd_en) begin
        rd_rst <= (rd_addr == AW'(0)) && !e0_valid;
      end
    end
  end

  assign rd_data = rd_rst ? RST_ENTRY : rd_q;

endmodule
`default_nettype wire

// File: src/ffba_walker.sv
`default_nettype none
module ffba_walker #(
  parameter int unsigned HEAP_BYTES   = ffba_pkg::DEF_HEAP_BYTES,
  parameter int unsigned HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES,
  parameter int unsigned MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS,
  parameter int unsigned ENT_W        = 41
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [ffba_pkg::ADDR_W-1:0]   heap_base,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_func,
  input  wire logic [ffba_pkg::REQ_W-1:0]    in_req,
  input  wire logic [ffba_pkg::ADDR_W-1:0]   in_raddr,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [ffba_pkg::ADDR_W-1:0]        out_addr,
  output ffba_pkg::status_t                  out_status,
  output logic                               rd_en,
  output logic [$clog2(MAX_BLOCKS)-1:0]      rd_addr,
  input  wire logic [ENT_W-1:0]              rd_data,
  output logic                               wr_en,
  output logic [$clog2(MAX_BLOCKS)-1:0]      wr_addr,
  output logic [ENT_W-1:0]                   wr_data
);
  import ffba_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned LK_W  = IDX_W + 1;
  localparam int unsigned ST_W  = $clog2(HEAP_BYTES);
  localparam int unsigned SZ_W  = ($clog2(HEAP_BYTES) + 1 > REQ_W) ?
                                  $clog2(HEAP_BYTES) + 1 : REQ_W;

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_FINISH} state_t;

  state_t            state;
  logic [IDX_W-1:0]  cur;
  logic              func_r;
  logic [REQ_W-1:0]  req_r;
  logic [ADDR_W-1:0] raddr_r;
  logic [LK_W-1:0]   count;
  logic [ADDR_W-1:0] res_addr;
  status_t           res_status;
  logic              split_pend;
  logic [ST_W-1:0]   sp_start;
  logic [SZ_W-1:0]   sp_size;
  logic [LK_W-1:0]   sp_link;

  logic [ST_W-1:0]   e_start;
  logic [SZ_W-1:0]   e_size;
  logic              e_busy;
  logic [LK_W-1:0]   e_link;
  logic [SZ_W-1:0]   req_ext;
  logic [SZ_W-1:0]   rest;
  logic [ADDR_W-1:0] uaddr;
  logic [SZ_W-1:0]   new_start;
  logic              fits;
  logic              can_split;
  logic              hit;
  logic              link_ok;

  assign {e_start, e_size, e_busy, e_link} = rd_data;
  assign req_ext   = SZ_W'(req_r);
  assign rest      = e_size - req_ext;
  assign fits      = !e_busy && (e_size >= req_ext);
  assign can_split = (rest >= SZ_W'(HEADER_BYTES)) && (count < LK_W'(MAX_BLOCKS));
  assign uaddr     = heap_base + ADDR_W'(e_start) + ADDR_W'(HEADER_BYTES);
  assign hit       = (uaddr == raddr_r);
  assign link_ok   = (e_link < count);
  assign new_start = SZ_W'(e_start) + SZ_W'(HEADER_BYTES) + req_ext;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    wr_en   = 1'b0;
    wr_addr = cur;
    wr_data = rd_data;
    case (state)
      S_IDLE: begin
        rd_en = in_valid;
      end
      S_EVAL: begin
        if (func_r == FN_ALLOC) begin
          if (fits) begin
            wr_en   = 1'b1;
            wr_data = can_split ? {e_start, req_ext, 1'b1, count} :
                                  {e_start, e_size, 1'b1, e_link};
          end else if (link_ok) begin
            rd_en   = 1'b1;
            rd_addr = e_link[IDX_W-1:0];
          end
        end else begin
          if (hit) begin
            wr_en   = 1'b1;
            wr_data = {e_start, e_size, 1'b0, e_link};
          end else if (link_ok) begin
            rd_en   = 1'b1;
            rd_addr = e_link[IDX_W-1:0];
          end
        end
      end
      S_FINISH: begin
        // trailing free block split off behind the granted one
        if (split_pend) begin
          wr_en   = 1'b1;
          wr_addr = count[IDX_W-1:0];
          wr_data = {sp_start, sp_size, 1'b0, sp_link};
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= LK_W'(1);
      split_pend <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // in S_FINISH the output register is reloaded below instead
      if (out_valid && out_ready && state != S_FINISH) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            func_r  <= in_func;
            req_r   <= in_req;
            raddr_r <= in_raddr;
            cur     <= '0;
            state   <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (func_r == FN_ALLOC) begin
            if (fits) begin
              res_addr   <= uaddr;
              res_status <= ST_OK;
              split_pend <= can_split;
              sp_start   <= new_start[ST_W-1:0];
              sp_size    <= rest - SZ_W'(HEADER_BYTES);
              sp_link    <= e_link;
              state      <= S_FINISH;
            end else if (link_ok) begin
              cur <= e_link[IDX_W-1:0];
            end else begin
              res_addr   <= '0;
              res_status <= ST_NO_FIT;
              state      <= S_FINISH;
            end
          end else begin
            if (hit) begin
              res_addr   <= '0;
              res_status <= ST_OK;
              state      <= S_FINISH;
            end else if (link_ok) begin
              cur <= e_link[IDX_W-1:0];
            end else begin
              res_addr   <= '0;
              res_status <= ST_BAD_ADDR;
              state      <= S_FINISH;
            end
          end
        end
        S_FINISH: begin
          if (split_pend) begin
            split_pend <= 1'b0;
            count      <= count + LK_W'(1);
          end
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            out_addr   <= res_addr;
            out_status <= res_status;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// File: src/first_fit_block_allocator_top.sv
// First-fit block allocator, no coalescing.
// Config: cfg_valid/cfg_ready/cfg_data write heap_base (always ready). Write
//   it only while the block is idle; it shifts every user address from then on.
// Input stream s_axis: tuser = func (0 allocate, 1 release); tdata holds
//   request_size and release_addr. One item is taken at a time.
// Output stream m_axis: one item per input, result_addr and status.
// Walk: the accepting edge registers the request and reads entry 0 of the
//   block table; S_EVAL then checks the chain, reading one entry per cycle,
//   and S_FINISH loads the output register, writing any split block there too.
// Input is accepted again once the result is loaded, even while
//   the previous result still waits in the output register. If the receiver
//   stalls, a finished item holds until the output register is free.
// Reset: one free block spanning the heap minus one header; no clearing pass,
//   the block is ready as soon as reset is released.
`default_nettype none
module first_fit_block_allocator_top #(
  parameter int unsigned HEAP_BYTES   = ffba_pkg::DEF_HEAP_BYTES,
  parameter int unsigned HEADER_BYTES = ffba_pkg::DEF_HEADER_BYTES,
  parameter int unsigned MAX_BLOCKS   = ffba_pkg::DEF_MAX_BLOCKS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ffba_pkg::ADDR_W-1:0]     cfg_data,
  input  wire logic                            s_axis_tvalid,
  output logic                                 s_axis_tready,
  // request_size [16:0], release_addr [48:17], zero fill above
  input  wire logic [ffba_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // func
  input  wire logic                            s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // result_addr [31:0], status [33:32], zero fill above
  output logic [ffba_pkg::M_TDATA_W-1:0]       m_axis_tdata
);
  import ffba_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_BLOCKS);
  localparam int unsigned LK_W  = IDX_W + 1;
  localparam int unsigned ST_W  = $clog2(HEAP_BYTES);
  localparam int unsigned SZ_W  = ($clog2(HEAP_BYTES) + 1 > REQ_W) ?
                                  $clog2(HEAP_BYTES) + 1 : REQ_W;
  localparam int unsigned ENT_W = ST_W + SZ_W + 1 + LK_W;
  localparam logic [ENT_W-1:0] RST_ENTRY =
    {ST_W'(0), SZ_W'(HEAP_BYTES - HEADER_BYTES), 1'b0, LK_W'(MAX_BLOCKS)};

  logic [ADDR_W-1:0] heap_base;
  logic [ADDR_W-1:0] out_addr;
  status_t           out_status;
  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic [ENT_W-1:0]  rd_data;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [ENT_W-1:0]  wr_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_base <= HEAP_BASE_RST;
    end else if (cfg_valid) begin
      heap_base <= cfg_data;
    end
  end

  ffba_block_mem #(
    .DEPTH     (MAX_BLOCKS),
    .ENT_W     (ENT_W),
    .RST_ENTRY (RST_ENTRY)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  ffba_walker #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BLOCKS   (MAX_BLOCKS),
    .ENT_W        (ENT_W)
  ) u_walker (
    .clk        (clk),
    .rst        (rst),
    .heap_base  (heap_base),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_func    (s_axis_tuser),
    .in_req     (s_axis_tdata[REQ_W-1:0]),
    .in_raddr   (s_axis_tdata[REQ_W+ADDR_W-1:REQ_W]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_addr   (out_addr),
    .out_status (out_status),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  assign m_axis_tdata = {(M_TDATA_W - ADDR_W - STATUS_W)'(0), out_status, out_addr};

endmodule
`default_nettype wire

// File: src/ffba_checker.sv
`default_nettype none
module ffba_checker (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_axis_tvalid,
  input  wire logic                            s_axis_tready,
  input  wire logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  input  wire logic [ffba_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
  import ffba_pkg::*;

  logic [STATUS_W-1:0] m_status;
  logic [ADDR_W-1:0]   m_addr;

  assign m_status = m_axis_tdata[ADDR_W+STATUS_W-1:ADDR_W];
  assign m_addr   = m_axis_tdata[ADDR_W-1:0];

  // one item at a time: a taken request closes the input for the walk
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while a walk is under way");

  // a result can only appear after a request has been taken
  a_result_needs_request: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> !s_axis_tready || $past(!s_axis_tready))
    else $error("result without a preceding request");

  a_fail_zero_addr: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_status != ST_OK |-> m_addr == '0)
    else $error("failed request reports a non-zero address");

  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind first_fit_block_allocator_top ffba_checker u_ffba_checker (.*);
`default_nettype wire
